// ===== rtl/cfsi_pkg.sv =====
// ----------------------------------------------------------------------------
// cfsi_pkg: shared types and constants for the cell flux surface integral
// Widths, lane indexes, controller states and the control bundle that the
// sequencer hands to the five component lanes.
// ----------------------------------------------------------------------------
package cfsi_pkg;

  // Q16.16 operand width and Q32.32 accumulator width
  localparam int DATA_W = 32;
  localparam int PROD_W = 2 * DATA_W;
  localparam int CNT_W  = $clog2(DATA_W);

  // conserved components: mass, x/y/z momentum, energy
  localparam int NCOMP = 5;
  localparam int ZCOMP = 3;

  // spatial_dims register
  localparam int DIMS_W = 2;
  localparam logic [DIMS_W-1:0] DIMS_RESET = 2'd2;
  localparam logic [DIMS_W-1:0] DIMS_3D    = 2'd3;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ACC,
    ST_DLOAD,
    ST_DIV,
    ST_FIN
  } cfsi_state_t;

  // control bundle from sequencer to lanes
  typedef struct packed {
    logic load;      // capture a face beat
    logic mul_step;  // one multiplier bit
    logic area_bit;  // current area bit, LSB first
    logic acc;       // add product into the running sum
    logic inward;    // face sign bit: add +p instead of -p
    logic zen;       // z momentum lane active
    logic dload;     // take magnitude of sum, start divide
    logic div_step;  // one quotient bit
    logic fin;       // write result, clear sums
  } cfsi_ctl_t;

endpackage

// ===== rtl/cfsi_lane.sv =====
// ----------------------------------------------------------------------------
// cfsi_lane: one conserved component
// Bit-serial signed x unsigned multiplier, saturating Q32.32 accumulator and
// a restoring divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
module cfsi_lane (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  cfsi_pkg::cfsi_ctl_t                  ctl,
  input  logic                                 en,
  input  logic signed [cfsi_pkg::DATA_W-1:0]   flux_in,
  input  logic        [cfsi_pkg::DATA_W-1:0]   vol,
  output logic        [cfsi_pkg::DATA_W-1:0]   res,
  output logic                                 flag
);

  localparam int W  = cfsi_pkg::DATA_W;
  localparam int PW = cfsi_pkg::PROD_W;
  localparam logic [W-1:0]  Q_MAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0]  Q_MIN = {1'b1, {(W-1){1'b0}}};
  localparam logic [PW-1:0] S_MAX = {1'b0, {(PW-1){1'b1}}};
  localparam logic [PW-1:0] S_MIN = {1'b1, {(PW-1){1'b0}}};

  logic signed [W-1:0]  flux_r;
  logic signed [W-1:0]  hi_r;
  logic        [W-1:0]  lo_r;
  logic signed [PW-1:0] sum_r, sum_nxt;
  logic        [W-1:0]  rem_r;
  logic        [W-1:0]  dq_r;
  logic                 neg_r, zero_r, big_r;

  logic signed [W:0]    mul_acc;
  logic        [PW-1:0] prod;
  logic        [PW:0]   p_ext, add_ext, s_ext;
  logic        [PW-1:0] sat_sum;
  logic        [PW-1:0] mag;
  logic        [W:0]    r2, diff;
  logic                 ge;

  // multiplier step: partial sum plus flux when the area bit is set
  always_comb begin
    mul_acc = {hi_r[W-1], hi_r} + (ctl.area_bit ? {flux_r[W-1], flux_r} : '0);
  end

  // saturating accumulate of -p (outward) or +p (inward)
  always_comb begin
    prod    = {hi_r, lo_r};
    p_ext   = {prod[PW-1], prod};
    add_ext = ctl.inward ? p_ext : (~p_ext + {{PW{1'b0}}, 1'b1});
    s_ext   = {sum_r[PW-1], sum_r} + add_ext;
    if (s_ext[PW] != s_ext[PW-1]) begin
      sat_sum = s_ext[PW] ? S_MIN : S_MAX;
    end else begin
      sat_sum = s_ext[PW-1:0];
    end
  end

  // magnitude of the sum for the divider
  always_comb begin
    mag = sum_r[PW-1] ? (~sum_r + {{(PW-1){1'b0}}, 1'b1}) : sum_r;
  end

  // restoring divide step
  always_comb begin
    r2   = {rem_r, dq_r[W-1]};
    ge   = (r2 >= {1'b0, vol});
    diff = r2 - {1'b0, vol};
  end

  // running sum, cleared at end of cell
  always_comb begin
    sum_nxt = sum_r;
    if (ctl.fin) begin
      sum_nxt = '0;
    end else if (ctl.acc && en) begin
      sum_nxt = sat_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
    end else begin
      sum_r <= sum_nxt;
    end
  end

  // datapath shift registers
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      flux_r <= flux_in;
      hi_r   <= '0;
      lo_r   <= '0;
    end else if (ctl.mul_step) begin
      hi_r <= mul_acc[W:1];
      lo_r <= {mul_acc[0], lo_r[W-1:1]};
    end
    if (ctl.dload) begin
      neg_r  <= sum_r[PW-1];
      zero_r <= (sum_r == '0);
      big_r  <= (mag[PW-1:W] >= vol);
      rem_r  <= mag[PW-1:W];
      dq_r   <= mag[W-1:0];
    end else if (ctl.div_step) begin
      rem_r <= ge ? diff[W-1:0] : r2[W-1:0];
      dq_r  <= {dq_r[W-2:0], ge};
    end
  end

  // final quotient with saturation
  always_comb begin
    res  = dq_r;
    flag = 1'b0;
    if (!en) begin
      res = '0;
    end else if (vol == '0) begin
      flag = 1'b1;
      res  = zero_r ? '0 : (neg_r ? Q_MIN : Q_MAX);
    end else if (big_r) begin
      flag = 1'b1;
      res  = neg_r ? Q_MIN : Q_MAX;
    end else if (neg_r) begin
      if (dq_r > Q_MIN) begin
        flag = 1'b1;
        res  = Q_MIN;
      end else begin
        res = ~dq_r + {{(W-1){1'b0}}, 1'b1};
      end
    end else if (dq_r[W-1]) begin
      flag = 1'b1;
      res  = Q_MAX;
    end
  end

endmodule

// ===== rtl/cfsi_ctrl.sv =====
// ----------------------------------------------------------------------------
// cfsi_ctrl: sequencer for the cell flux surface integral
// Holds the dims register, the face area shift register and the volume,
// steps the lanes through multiply, accumulate and divide, and owns the
// result valid flag.
// ----------------------------------------------------------------------------
module cfsi_ctrl (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [cfsi_pkg::DIMS_W-1:0]         cfg_wr_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [cfsi_pkg::DATA_W-1:0]         in_face_area,
  input  logic signed [1:0]                   in_out_sign,
  input  logic [cfsi_pkg::DATA_W-1:0]         in_cell_volume,
  input  logic                                in_last_face,
  input  logic                                out_stall,
  output logic                                out_valid,
  output cfsi_pkg::cfsi_ctl_t                 ctl,
  output logic [cfsi_pkg::DATA_W-1:0]         vol
);

  localparam int W  = cfsi_pkg::DATA_W;
  localparam int CW = cfsi_pkg::CNT_W;
  localparam logic [CW-1:0] CNT_LAST = CW'(W - 1);

  cfsi_pkg::cfsi_state_t state_r, state_nxt;
  logic [CW-1:0]               cnt_r;
  logic [W-1:0]                area_r;
  logic [W-1:0]                vol_r;
  logic                        inward_r, last_r, zen_r;
  logic [cfsi_pkg::DIMS_W-1:0] dims_r;
  logic                        out_valid_r;
  logic                        slot_free;

  assign slot_free = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign vol       = vol_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      cfsi_pkg::ST_IDLE:  if (in_valid) state_nxt = cfsi_pkg::ST_MUL;
      cfsi_pkg::ST_MUL:   if (cnt_r == CNT_LAST) state_nxt = cfsi_pkg::ST_ACC;
      cfsi_pkg::ST_ACC:   state_nxt = last_r ? cfsi_pkg::ST_DLOAD : cfsi_pkg::ST_IDLE;
      cfsi_pkg::ST_DLOAD: state_nxt = cfsi_pkg::ST_DIV;
      cfsi_pkg::ST_DIV:   if (cnt_r == CNT_LAST) state_nxt = cfsi_pkg::ST_FIN;
      cfsi_pkg::ST_FIN:   if (slot_free) state_nxt = cfsi_pkg::ST_IDLE;
      default:            state_nxt = cfsi_pkg::ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    ctl          = '0;
    ctl.area_bit = area_r[0];
    ctl.inward   = inward_r;
    ctl.zen      = zen_r;
    in_stall     = 1'b1;
    unique case (state_r)
      cfsi_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        ctl.load = in_valid;
      end
      cfsi_pkg::ST_MUL:   ctl.mul_step = 1'b1;
      cfsi_pkg::ST_ACC:   ctl.acc      = 1'b1;
      cfsi_pkg::ST_DLOAD: ctl.dload    = 1'b1;
      cfsi_pkg::ST_DIV:   ctl.div_step = 1'b1;
      cfsi_pkg::ST_FIN:   ctl.fin      = slot_free;
      default:            in_stall     = 1'b1;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cfsi_pkg::ST_IDLE;
      cnt_r       <= '0;
      dims_r      <= cfsi_pkg::DIMS_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= (ctl.mul_step || ctl.div_step) ? cnt_r + 1'b1 : '0;
      if (cfg_wr_en) begin
        dims_r <= cfg_wr_data;
      end
      if (ctl.fin) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // face beat capture and area bit shifter
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      area_r   <= in_face_area;
      vol_r    <= in_cell_volume;
      inward_r <= in_out_sign[1];
      last_r   <= in_last_face;
      zen_r    <= (dims_r == cfsi_pkg::DIMS_3D);
    end else if (ctl.mul_step) begin
      area_r <= {1'b0, area_r[W-1:1]};
    end
  end

endmodule

// ===== rtl/cell_flux_surface_integral.sv =====
// ----------------------------------------------------------------------------
// cell_flux_surface_integral: finite volume flux divergence of one cell
// Accumulates flux times negated signed face area over the faces of a cell
// and divides the five sums by the cell volume on the last face.
// ----------------------------------------------------------------------------
// A face beat is accepted, then the bit-serial multipliers form flux times
// area one area bit per cycle, and the product is added with saturation
// into the Q32.32 sums. The last face of a cell then takes the sum
// magnitudes, runs the restoring dividers that give one quotient bit per
// cycle, and writes the result register once the result slot is free.
// All five components run in parallel lanes; the z lane is idle unless
// spatial_dims is 3. A finished result waits in its own register, and the
// next face is accepted meanwhile; only a further last face waits for that
// register to be taken.
module cell_flux_surface_integral (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic        [cfsi_pkg::DIMS_W-1:0]  cfg_wr_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [cfsi_pkg::DATA_W-1:0]  in_mass_flux,
  input  logic signed [cfsi_pkg::DATA_W-1:0]  in_xmom_flux,
  input  logic signed [cfsi_pkg::DATA_W-1:0]  in_ymom_flux,
  input  logic signed [cfsi_pkg::DATA_W-1:0]  in_zmom_flux,
  input  logic signed [cfsi_pkg::DATA_W-1:0]  in_energy_flux,
  input  logic        [cfsi_pkg::DATA_W-1:0]  in_face_area,
  input  logic signed [1:0]                   in_out_sign,
  input  logic        [cfsi_pkg::DATA_W-1:0]  in_cell_volume,
  input  logic                                in_last_face,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [cfsi_pkg::DATA_W-1:0]  out_dmass_dt,
  output logic signed [cfsi_pkg::DATA_W-1:0]  out_dxmom_dt,
  output logic signed [cfsi_pkg::DATA_W-1:0]  out_dymom_dt,
  output logic signed [cfsi_pkg::DATA_W-1:0]  out_dzmom_dt,
  output logic signed [cfsi_pkg::DATA_W-1:0]  out_denergy_dt,
  output logic                                out_overflow_flag
);

  localparam int W = cfsi_pkg::DATA_W;
  localparam int N = cfsi_pkg::NCOMP;

  cfsi_pkg::cfsi_ctl_t ctl;
  logic        [W-1:0] vol;
  logic signed [W-1:0] flux [N];
  logic        [W-1:0] res  [N];
  logic        [N-1:0] lane_flag;

  logic signed [W-1:0] dmass_r, dxmom_r, dymom_r, dzmom_r, denergy_r;
  logic                ovf_r;

  assign flux[0] = in_mass_flux;
  assign flux[1] = in_xmom_flux;
  assign flux[2] = in_ymom_flux;
  assign flux[3] = in_zmom_flux;
  assign flux[4] = in_energy_flux;

  // sequencer
  cfsi_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_face_area   (in_face_area),
    .in_out_sign    (in_out_sign),
    .in_cell_volume (in_cell_volume),
    .in_last_face   (in_last_face),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .ctl            (ctl),
    .vol            (vol)
  );

  // component lanes
  for (genvar i = 0; i < N; i++) begin : g_lane
    cfsi_lane u_lane (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl     (ctl),
      .en      ((i == cfsi_pkg::ZCOMP) ? ctl.zen : 1'b1),
      .flux_in (flux[i]),
      .vol     (vol),
      .res     (res[i]),
      .flag    (lane_flag[i])
    );
  end

  // result register
  always_ff @(posedge clk) begin
    if (ctl.fin) begin
      dmass_r   <= res[0];
      dxmom_r   <= res[1];
      dymom_r   <= res[2];
      dzmom_r   <= res[3];
      denergy_r <= res[4];
      ovf_r     <= |lane_flag;
    end
  end

  assign out_dmass_dt      = dmass_r;
  assign out_dxmom_dt      = dxmom_r;
  assign out_dymom_dt      = dymom_r;
  assign out_dzmom_dt      = dzmom_r;
  assign out_denergy_dt    = denergy_r;
  assign out_overflow_flag = ovf_r;

  // a face beat starts a multiply, so the input side closes next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not stalled after face beat");

  // results are written only into a free slot
  a_fin_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.fin |-> (!out_valid || !out_stall))
    else $error("result written over a pending beat");

  // a result appears only after a writeback
  a_valid_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(ctl.fin))
    else $error("result valid without writeback");

  // the z lane reports nothing while idle in two dimensions
  a_z_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.fin && !ctl.zen) |=> (out_dzmom_dt == '0))
    else $error("z result nonzero in two dimensions");

endmodule
